// ===== rtl/kiss_frame_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// KISS frame decoder assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef KISS_FRAME_DECODER_DEFINES_SVH
`define KISS_FRAME_DECODER_DEFINES_SVH

`ifndef SYNTH

// Antecedent in a cycle implies the consequent in the same cycle.
`define KFD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kiss_frame_decoder: same-cycle check failed");

// Antecedent in a cycle implies the consequent in the next cycle.
`define KFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kiss_frame_decoder: next-cycle check failed");

`else

`define KFD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define KFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/kfd_pkg.sv =====
// ----------------------------------------------------------------------------
// KISS frame decoder package
// Byte codes, command codes, result kinds, setting defaults and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kfd_pkg;

    localparam int MAX_FRAME_LEN_DEF = 512;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int IDX_W   = 9;
    localparam int LEN_W   = 10;
    localparam int TIME_W  = 12;
    localparam int CMD_W   = 5;

    // Framing bytes.
    localparam logic [BYTE_W-1:0] FRAME_END = 8'hC0;
    localparam logic [BYTE_W-1:0] FRAME_ESC = 8'hDB;
    localparam logic [BYTE_W-1:0] TRANS_END = 8'hDC;
    localparam logic [BYTE_W-1:0] TRANS_ESC = 8'hDD;
    localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
    localparam logic [3:0]        PORT_MASK = 4'hF;

    // Command codes held in the current command register.
    localparam logic [CMD_W-1:0] OP_DATA    = 5'd0;
    localparam logic [CMD_W-1:0] OP_DELAY   = 5'd1;
    localparam logic [CMD_W-1:0] OP_PERSIST = 5'd2;
    localparam logic [CMD_W-1:0] OP_SLOT    = 5'd3;
    localparam logic [CMD_W-1:0] OP_TAIL    = 5'd4;
    localparam logic [CMD_W-1:0] OP_FLOW    = 5'd15;
    localparam logic [CMD_W-1:0] OP_NONE    = 5'd16;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_BYTE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SETTING  = 2'd2;

    // Setting values after reset.
    localparam logic [TIME_W-1:0] DELAY_RST   = 12'd350;
    localparam logic [TIME_W-1:0] TAIL_RST    = 12'd50;
    localparam logic [TIME_W-1:0] SLOT_RST    = 12'd200;
    localparam logic [BYTE_W-1:0] PERSIST_RST = 8'd63;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data_byte;
        logic [IDX_W-1:0]  byte_index;
        logic [LEN_W-1:0]  frame_length;
        logic [TIME_W-1:0] tx_delay;
        logic [TIME_W-1:0] tx_tail;
        logic [TIME_W-1:0] slot_time;
        logic [BYTE_W-1:0] persistence;
        logic              flow_control;
    } kfd_result_t;

    typedef struct packed {
        logic inside_frame;
        logic escape_pending;
        logic frame_full;
    } kfd_status_t;

endpackage

// ===== rtl/kfd_byte_if.sv =====
// ----------------------------------------------------------------------------
// KISS host byte channel
// Valid/ready channel carrying one serial byte from the host per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kfd_byte_if
    import kfd_pkg::*;
();

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);

endinterface

// ===== rtl/kfd_result_if.sv =====
// ----------------------------------------------------------------------------
// KISS decoder result channel
// Valid/ready channel carrying one decoded event and the held settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kfd_result_if
    import kfd_pkg::*;
();

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_byte;
    logic [IDX_W-1:0]  byte_index;
    logic [LEN_W-1:0]  frame_length;
    logic [TIME_W-1:0] tx_delay;
    logic [TIME_W-1:0] tx_tail;
    logic [TIME_W-1:0] slot_time;
    logic [BYTE_W-1:0] persistence;
    logic              flow_control;

    modport source (
        output valid, output kind, output data_byte, output byte_index,
        output frame_length, output tx_delay, output tx_tail, output slot_time,
        output persistence, output flow_control, input ready
    );
    modport sink (
        input valid, input kind, input data_byte, input byte_index,
        input frame_length, input tx_delay, input tx_tail, input slot_time,
        input persistence, input flow_control, output ready
    );

endinterface

// ===== rtl/kiss_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// KISS frame decoder
// Turns the host serial byte stream into payload, frame-end and setting words.
// ----------------------------------------------------------------------------
// Usage: host bytes enter on the host channel, one word per byte. Each byte
// yields at most one word on the events channel: a stored payload byte with
// its index, a frame-complete word with the payload length, or a settings
// word after a TX delay, persistence, slot time, TX tail or flow-control
// byte. Every events word also carries the current held settings.
// An accepted byte waits in the input register, then the decoder core updates
// its state and loads the output register. Throughput is one byte per cycle
// while the output word is not stalled; the core's state update sets this
// rate. Bytes that cause no word still step the core and leave the input
// register free.
// While the receiver stalls, the output word holds and one more byte may sit
// in the input register; after that host.ready drops until the word is taken.
// Reset clears the framing state, restores the default settings and empties
// both registers; host.ready is high on the first cycle after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "kiss_frame_decoder_defines.svh"

module kiss_frame_decoder
    import kfd_pkg::*;
#(
    parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF
) (
    input  logic clk,
    input  logic rst_n,
    kfd_byte_if.sink     host,
    kfd_result_if.source events
);

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    kfd_result_t       out_data_reg;

    logic              advance;
    logic              out_stall;
    logic              close_word;
    logic              full_emit;
    logic              core_emit;
    kfd_result_t       core_result;
    kfd_status_t       core_status;

    // The held byte moves on whenever the output register is free or being taken.
    assign out_stall  = out_valid_reg && !events.ready;
    assign advance    = in_valid_reg && !out_stall;
    assign host.ready = !in_valid_reg || advance;

    assign close_word = advance && core_emit && core_result.kind == KIND_COMPLETE;
    assign full_emit  = advance && core_status.frame_full && core_emit;

    always_comb
    begin
        in_valid_next = host.ready ? host.valid : in_valid_reg;

        if (advance)
            out_valid_next = core_emit;
        else if (events.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (host.valid && host.ready)
            in_byte_reg <= host.rx_byte;
        if (advance && core_emit)
            out_data_reg <= core_result;
    end

    kfd_core #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .emit    (core_emit),
        .result  (core_result),
        .status  (core_status)
    );

    assign events.valid        = out_valid_reg;
    assign events.kind         = out_data_reg.kind;
    assign events.data_byte    = out_data_reg.data_byte;
    assign events.byte_index   = out_data_reg.byte_index;
    assign events.frame_length = out_data_reg.frame_length;
    assign events.tx_delay     = out_data_reg.tx_delay;
    assign events.tx_tail      = out_data_reg.tx_tail;
    assign events.slot_time    = out_data_reg.slot_time;
    assign events.persistence  = out_data_reg.persistence;
    assign events.flow_control = out_data_reg.flow_control;

    // A held byte with a stalled output word must block the host side.
    `KFD_ASSERT_SAME(a_no_overrun, clk, rst_n, in_valid_reg && out_stall, !host.ready)
    // Closing a data frame leaves the decoder outside any frame.
    `KFD_ASSERT_NEXT(a_close_frame, clk, rst_n, close_word, !core_status.inside_frame)
    // A full frame stores no further payload bytes.
    `KFD_ASSERT_SAME(a_full_drops, clk, rst_n, full_emit, core_result.kind != KIND_BYTE)

endmodule

// ===== rtl/kfd_core.sv =====
// ----------------------------------------------------------------------------
// KISS decoder core
// Framing state, escape handling, payload counter and held settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kfd_core
    import kfd_pkg::*;
#(
    parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              emit,
    output kfd_result_t       result,
    output kfd_status_t       status
);

    localparam int CNT_W = $clog2(MAX_FRAME_LEN + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_LEN);

    logic              inside_reg, inside_next;
    logic              esc_reg, esc_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TIME_W-1:0] delay_reg, delay_next;
    logic [TIME_W-1:0] tail_reg, tail_next;
    logic [TIME_W-1:0] slot_reg, slot_next;
    logic [BYTE_W-1:0] persist_reg, persist_next;
    logic              flow_reg, flow_next;

    logic [TIME_W-1:0] byte_wide;
    logic [TIME_W-1:0] byte_x10;
    logic [BYTE_W-1:0] unescaped;
    logic              frame_full;
    logic [KIND_W-1:0] kind_sel;

    assign byte_wide  = TIME_W'(rx_byte);
    assign byte_x10   = (byte_wide << 3) + (byte_wide << 1);
    assign frame_full = (count_reg >= MAX_CNT);

    always_comb
    begin
        unescaped = rx_byte;
        if (esc_reg)
        begin
            if (rx_byte == TRANS_END)
                unescaped = FRAME_END;
            else if (rx_byte == TRANS_ESC)
                unescaped = FRAME_ESC;
        end
    end

    // Next state of the framing logic and the settings.
    always_comb
    begin
        inside_next  = inside_reg;
        esc_next     = esc_reg;
        cmd_next     = cmd_reg;
        count_next   = count_reg;
        delay_next   = delay_reg;
        tail_next    = tail_reg;
        slot_next    = slot_reg;
        persist_next = persist_reg;
        flow_next    = flow_reg;
        emit         = 1'b0;
        kind_sel     = KIND_SETTING;

        if (inside_reg && rx_byte == FRAME_END && cmd_reg == OP_DATA)
        begin
            inside_next = 1'b0;
            emit        = 1'b1;
            kind_sel    = KIND_COMPLETE;
        end
        else if (rx_byte == FRAME_END)
        begin
            inside_next = 1'b1;
            cmd_next    = OP_NONE;
            count_next  = '0;
        end
        else if (inside_reg && !frame_full)
        begin
            if (count_reg == '0 && cmd_reg == OP_NONE)
            begin
                cmd_next = {1'b0, rx_byte[3:0] & PORT_MASK};
            end
            else
            begin
                case (cmd_reg)
                    OP_DATA:
                    begin
                        if (rx_byte == FRAME_ESC)
                        begin
                            esc_next = 1'b1;
                        end
                        else
                        begin
                            esc_next   = 1'b0;
                            count_next = count_reg + CNT_W'(1);
                            emit       = 1'b1;
                            kind_sel   = KIND_BYTE;
                        end
                    end
                    OP_DELAY:
                    begin
                        delay_next = byte_x10;
                        emit       = 1'b1;
                    end
                    OP_TAIL:
                    begin
                        tail_next = byte_x10;
                        emit      = 1'b1;
                    end
                    OP_SLOT:
                    begin
                        slot_next = byte_x10;
                        emit      = 1'b1;
                    end
                    OP_PERSIST:
                    begin
                        persist_next = rx_byte;
                        emit         = 1'b1;
                    end
                    OP_FLOW:
                    begin
                        flow_next = (rx_byte != BYTE_ZERO);
                        emit      = 1'b1;
                    end
                    default:
                    begin
                        emit = 1'b0;
                    end
                endcase
            end
        end
    end

    // Result fields; the settings reported are the ones after this byte.
    always_comb
    begin
        result.kind         = kind_sel;
        result.data_byte    = (kind_sel == KIND_BYTE) ? unescaped : '0;
        result.byte_index   = (kind_sel == KIND_BYTE) ? IDX_W'(count_reg) : '0;
        result.frame_length = (kind_sel == KIND_COMPLETE) ? LEN_W'(count_reg) : '0;
        result.tx_delay     = delay_next;
        result.tx_tail      = tail_next;
        result.slot_time    = slot_next;
        result.persistence  = persist_next;
        result.flow_control = flow_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg  <= 1'b0;
            esc_reg     <= 1'b0;
            cmd_reg     <= OP_NONE;
            count_reg   <= '0;
            delay_reg   <= DELAY_RST;
            tail_reg    <= TAIL_RST;
            slot_reg    <= SLOT_RST;
            persist_reg <= PERSIST_RST;
            flow_reg    <= 1'b0;
        end
        else if (step)
        begin
            inside_reg  <= inside_next;
            esc_reg     <= esc_next;
            cmd_reg     <= cmd_next;
            count_reg   <= count_next;
            delay_reg   <= delay_next;
            tail_reg    <= tail_next;
            slot_reg    <= slot_next;
            persist_reg <= persist_next;
            flow_reg    <= flow_next;
        end
    end

    assign status.inside_frame   = inside_reg;
    assign status.escape_pending = esc_reg;
    assign status.frame_full     = frame_full;

endmodule
